// ===== rtl/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
// Used by mbps_cell and masked_byte_pattern_scanner; depends on nothing.
`timescale 1ns / 1ps
package mbps_pkg;

    localparam int NUM_POS     = 16;  // pattern positions backed by register bits
    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 3;
    localparam int OFFSET_W    = 48;
    localparam int LEN_CFG_W   = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    // Register indexes of the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_MODES  = 8'd3;

    // Compare mode codes; the remaining codes never match.
    typedef enum logic [MODE_W-1:0] {
        MODE_ANY = 3'd0,
        MODE_EQ  = 3'd1,
        MODE_NEQ = 3'd2,
        MODE_GT  = 3'd3,
        MODE_LT  = 3'd4
    } mode_e_t;

    // Pattern configuration seen by every cell.
    typedef struct packed {
        logic [NUM_POS-1:0][BYTE_W-1:0] pattern;
        logic [NUM_POS-1:0][MODE_W-1:0] modes;
    } pat_cfg_t;

endpackage

// ===== rtl/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner: configuration registers,
// a chain of mbps_cell window cells, byte count, offset counter and output register.
// Depends on mbps_pkg and mbps_cell.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------
//  s_       | in        | s_tvalid / s_tready | s_tdata: data_byte; s_tuser: stream_start
//  m_       | out       | m_tvalid / m_tready | m_tdata: match_offset
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index: register; cfg_data: value
//
// One byte per cycle: every cell compares its incoming byte in the transfer cycle
// and the match result is loaded at that edge, showing on m_ in the next cycle.
// A new byte is taken whenever the output register is empty or being drained,
// so a stall on m_ holds the input only while a result waits and is not taken.
// Synchronous active-low reset clears the window, counters, registers and
// output valid; configuration writes are always taken (cfg_ready stays high).
`timescale 1ns / 1ps
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] stream_start
    // match results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbps_pkg::OFFSET_W-1:0]     m_tdata,   // [47:0] match_offset
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    // configuration registers
    logic [LEN_CFG_W-1:0]  len_cfg_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [OFFSET_W-1:0]   modes_reg;

    // stream state
    logic [LEN_W-1:0]    seen_reg,   seen_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [OFFSET_W-1:0] cur_offset;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0] m_offset_reg, m_offset_next;

    logic                    accept;
    logic [LEN_W-1:0]        eff_len;
    logic [CMP_W-1:0]        len_cfg_ext;
    logic [OFFSET_W-1:0]     len_less_one;
    pat_cfg_t                cfg;
    logic [MAX_PATTERN-1:0]  pos_ok;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] chain;
    logic                    hit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Decode configuration writes; unknown indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg  <= LEN_CFG_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            modes_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: len_cfg_reg  <= cfg_data[LEN_CFG_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                REG_COMPARE_MODES:  modes_reg    <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.modes   = modes_reg;

    // Clamp the programmed length to 1..MAX_PATTERN.
    assign len_cfg_ext = CMP_W'(len_cfg_reg);
    always_comb begin
        if (len_cfg_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_cfg_ext > CMP_W'(MAX_PATTERN)) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = len_cfg_ext[LEN_W-1:0];
        end
    end

    // Window cells: cell 0 takes the input byte, each later cell its neighbor's.
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [BYTE_W-1:0] feed;
        if (j == 0) begin : g_head
            assign feed = s_tdata;
        end else begin : g_body
            assign feed = chain[j-1];
        end
        mbps_cell #(
            .INDEX (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (accept),
            .clear    (s_tuser),
            .byte_in  (feed),
            .eff_len  (eff_len),
            .cfg      (cfg),
            .byte_out (chain[j]),
            .pos_ok   (pos_ok[j])
        );
    end

    // Byte count and offset: a stream start clears them before this byte counts.
    always_comb begin
        if (s_tuser) begin
            seen_next  = LEN_W'(1);
            cur_offset = '0;
        end else begin
            seen_next  = (seen_reg < MAX_LEN) ? seen_reg + LEN_W'(1) : seen_reg;
            cur_offset = offset_reg;
        end
        offset_next = (cur_offset < OFFSET_MAX) ? cur_offset + OFFSET_W'(1) : cur_offset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= '0;
            offset_reg <= '0;
        end else if (accept) begin
            seen_reg   <= seen_next;
            offset_reg <= offset_next;
        end
    end

    // A full window match needs enough bytes and every active position passing.
    assign hit          = (seen_next >= eff_len) && (&pos_ok);
    assign len_less_one = OFFSET_W'(eff_len) - OFFSET_W'(1);

    // Load a new result on transfer; drop the held one once taken.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_offset_next = m_offset_reg;
        if (accept) begin
            m_valid_next  = hit;
            m_offset_next = (cur_offset >= len_less_one) ? cur_offset - len_less_one : '0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_offset_reg <= m_offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_offset_reg;

endmodule

// ===== rtl/mbps_cell.sv =====
// One window cell of the scanner: holds one stream byte, hands it on to the
// next cell and checks its incoming byte against its pattern position. Uses mbps_pkg.
`timescale 1ns / 1ps
module mbps_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      clear,
    input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
    input  logic [LEN_W-1:0]          eff_len,
    input  mbps_pkg::pat_cfg_t        cfg,
    output logic [mbps_pkg::BYTE_W-1:0] byte_out,
    output logic                      pos_ok
);
    import mbps_pkg::*;

    // Wide enough to hold NUM_POS, so positions past the register bits are seen.
    localparam int POS_W = (LEN_W > 5) ? LEN_W : 5;
    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic [POS_W-1:0]  len_ext;
    logic [POS_W-1:0]  pos;
    logic              active;
    logic              pass;
    logic [BYTE_W-1:0] pat;
    logic [MODE_W-1:0] mode;

    // A new stream clears the window; the first cell still takes the new byte.
    always_comb begin
        if (clear && (INDEX != 0)) begin
            byte_next = '0;
        end else begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else if (advance) begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    // This cell lines up with pattern position len-1-INDEX.
    assign len_ext = POS_W'(eff_len);
    assign active  = IDX < len_ext;
    assign pos     = len_ext - IDX - POS_W'(1);
    assign pat     = cfg.pattern[pos[3:0]];
    assign mode    = cfg.modes[pos[3:0]];

    always_comb begin
        if (pos >= POS_W'(NUM_POS)) begin
            pass = 1'b1;
        end else begin
            unique case (mode)
                MODE_ANY: pass = 1'b1;
                MODE_EQ:  pass = (byte_next == pat);
                MODE_NEQ: pass = (byte_next != pat);
                MODE_GT:  pass = (byte_next > pat);
                MODE_LT:  pass = (byte_next < pat);
                default:  pass = 1'b0;
            endcase
        end
    end

    assign pos_ok = !active || pass;

endmodule
